[src/pedf_pkg.sv]
// Shared package for the prefix edit distance filter
// Holds op codes, register indexes, fsm states and controller/datapath structs
`timescale 1ns / 1ps

package pedf_pkg;

    // default query capacity
    localparam int MAX_QUERY_LEN_DEF = 64;

    // register reset values and the space character
    localparam int          THRESHOLD_RESET = 2;
    localparam logic        SKIP_RESET      = 1'b1;
    localparam logic [7:0]  SPACE_CHAR      = 8'h20;

    // configuration register indexes
    localparam int               CFG_IDX_W     = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP      = 1'b1;

    // request op codes
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_CAND   = 2'd2,
        OP_END    = 2'd3
    } op_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROW,
        ST_FINISH
    } ctrl_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic clear_query;
        logic append;
        logic restart;
        logic start_row;
        logic pad;
        logic run;
        logic emit;
    } ctrl_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic dropped;
        logic ql_zero;
        logic rows_short;
        logic row_last;
        logic out_free;
    } dp_status_t;

endpackage

[src/prefix_edit_distance_filter_unit.sv]
// Top level of the prefix edit distance filter: controller plus datapath
// Depends on pedf_pkg, pedf_ctrl, pedf_datapath (and pedf_ram through it)
//
// Approximate prefix matcher on Levenshtein distance. Load a query with op 0
// (clear) and op 1 (append char), then stream each candidate with op 2 and
// finish it with op 3, which returns distance and is_match (distance below
// match_threshold). A candidate character starts a column sweep that reads
// one cell per cycle from the column ram, which has a registered read port.
// A candidate character that is a skipped space or lies past the query
// length starts no sweep. Op 3 pads a short candidate with mismatch rows up
// to the query length, then waits for the output to free up.
// The column restart after each candidate clears the per-entry valid
// bits, so there is no clearing pass after reset. Configuration is always
// ready and should only be written while the block is idle.
`timescale 1ns / 1ps

module prefix_edit_distance_filter_unit #(
    parameter int  MAX_QUERY_LEN = pedf_pkg::MAX_QUERY_LEN_DEF,
    localparam int LW = $clog2(MAX_QUERY_LEN + 1),
    localparam int TW = $clog2(MAX_QUERY_LEN + 2)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     op,
    input  logic [7:0]                     ch,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [LW-1:0]                  distance,
    output logic                           is_match,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pedf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [TW-1:0]                  cfg_data
);

    import pedf_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // controller
    pedf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .op       (op),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    pedf_datapath #(
        .MAX_QUERY_LEN (MAX_QUERY_LEN)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ch        (ch),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .distance  (distance),
        .is_match  (is_match),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

[src/pedf_ram.sv]
// Generic single write port, single read port ram with registered read
// No dependencies
`timescale 1ns / 1ps

module pedf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/pedf_datapath.sv]
// Datapath: config registers, query ram, dp column ram with valid bits,
// one-cell-per-cycle row update and the result register; uses pedf_pkg, pedf_ram
`timescale 1ns / 1ps

module pedf_datapath #(
    parameter int  MAX_QUERY_LEN = pedf_pkg::MAX_QUERY_LEN_DEF,
    localparam int LW = $clog2(MAX_QUERY_LEN + 1),
    localparam int TW = $clog2(MAX_QUERY_LEN + 2)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [7:0]                        ch,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pedf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [TW-1:0]                     cfg_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [LW-1:0]                     distance,
    output logic                              is_match,
    input  pedf_pkg::ctrl_cmd_t               cmd,
    output pedf_pkg::dp_status_t              status
);

    import pedf_pkg::*;

    localparam int AW = (MAX_QUERY_LEN > 1) ? $clog2(MAX_QUERY_LEN) : 1;

    logic [TW-1:0]            thr_reg;
    logic                     skip_reg;
    logic [LW-1:0]            ql_reg;
    logic [LW-1:0]            rows_reg;
    logic [LW-1:0]            k_reg;
    logic [LW-1:0]            left_reg;
    logic [LW-1:0]            diag_reg;
    logic [7:0]               ch_reg;
    logic                     pad_reg;
    logic [MAX_QUERY_LEN-1:0] vld_reg;
    logic                     vld_q_reg;
    logic                     out_valid_reg;
    logic [LW-1:0]            dist_reg;
    logic                     match_reg;

    logic                     cfg_fire;
    logic                     dropped;
    logic                     append_ok;
    logic [AW-1:0]            rd_addr;
    logic [LW-1:0]            k_prev;
    logic [AW-1:0]            wr_addr;
    logic                     cell_we;
    logic [7:0]               qc_q;
    logic [LW-1:0]            dp_q;
    logic [LW-1:0]            above;
    logic                     cost;
    logic [LW:0]              up_sum;
    logic [LW:0]              left_sum;
    logic [LW:0]              diag_sum;
    logic [LW:0]              min_a;
    logic [LW:0]              cell_new;
    logic [LW-1:0]            dist_sel;

    // config write port, always ready
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= TW'(THRESHOLD_RESET);
            skip_reg <= SKIP_RESET;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                CFG_THRESHOLD: thr_reg  <= cfg_data;
                CFG_SKIP:      skip_reg <= cfg_data[0];
                default:       thr_reg  <= thr_reg;
            endcase
        end
    end

    // character filtering and query append
    assign dropped   = skip_reg && (ch == SPACE_CHAR);
    assign append_ok = cmd.append && !dropped && (ql_reg < LW'(MAX_QUERY_LEN));

    // addresses: read entry k+1, write entry k
    assign rd_addr = k_reg[AW-1:0];
    assign k_prev  = k_reg - 1'b1;
    assign wr_addr = k_prev[AW-1:0];
    assign cell_we = cmd.run && (k_reg != '0);

    pedf_ram #(
        .WIDTH (8),
        .DEPTH (MAX_QUERY_LEN)
    ) u_query_ram (
        .clk   (clk),
        .we    (append_ok),
        .waddr (ql_reg[AW-1:0]),
        .wdata (ch),
        .raddr (rd_addr),
        .rdata (qc_q)
    );

    pedf_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_QUERY_LEN)
    ) u_col_ram (
        .clk   (clk),
        .we    (cell_we),
        .waddr (wr_addr),
        .wdata (cell_new[LW-1:0]),
        .raddr (rd_addr),
        .rdata (dp_q)
    );

    // cell update: min of above+1, left+1, diag+cost
    assign above    = vld_q_reg ? dp_q : k_reg;
    assign cost     = pad_reg || (qc_q != ch_reg);
    assign up_sum   = {1'b0, above} + 1'b1;
    assign left_sum = {1'b0, left_reg} + 1'b1;
    assign diag_sum = {1'b0, diag_reg} + {{LW{1'b0}}, cost};
    assign min_a    = (up_sum < left_sum) ? up_sum : left_sum;
    assign cell_new = (min_a < diag_sum) ? min_a : diag_sum;

    // query length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ql_reg <= '0;
        end
        else if (cmd.clear_query)
        begin
            ql_reg <= '0;
        end
        else if (append_ok)
        begin
            ql_reg <= ql_reg + 1'b1;
        end
    end

    // column valid bits, an invalid entry y reads as y
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            vld_q_reg <= 1'b0;
        end
        else
        begin
            vld_q_reg <= vld_reg[rd_addr];
            if (cmd.restart)
            begin
                vld_reg <= '0;
            end
            else if (cell_we)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // row bookkeeping and sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= '0;
            k_reg    <= '0;
        end
        else if (cmd.restart)
        begin
            rows_reg <= '0;
        end
        else if (cmd.start_row)
        begin
            rows_reg <= rows_reg + 1'b1;
            k_reg    <= '0;
        end
        else if (cmd.run)
        begin
            k_reg <= k_reg + 1'b1;
        end
    end

    // sweep payload: left, diagonal, row character
    always_ff @(posedge clk)
    begin
        if (cmd.start_row)
        begin
            left_reg <= rows_reg + 1'b1;
            diag_reg <= rows_reg;
            ch_reg   <= ch;
            pad_reg  <= cmd.pad;
        end
        else if (cell_we)
        begin
            left_reg <= cell_new[LW-1:0];
            diag_reg <= above;
        end
    end

    // result register
    assign dist_sel = (ql_reg == '0) ? '0 : left_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            dist_reg  <= dist_sel;
            match_reg <= (TW'(dist_sel) < thr_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign distance  = dist_reg;
    assign is_match  = match_reg;

    // status to controller, row_last only meaningful during a sweep
    assign status.dropped    = dropped;
    assign status.ql_zero    = (ql_reg == '0);
    assign status.rows_short = (rows_reg < ql_reg);
    assign status.row_last   = (k_reg == ql_reg);
    assign status.out_free   = !out_valid_reg || out_ready;

    // rows consumed never pass the query length
    a_rows_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rows_reg <= ql_reg)
        else $error("rows consumed exceed query length");

    // cell writes stay inside the query
    a_cell_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cell_we |-> (k_reg <= ql_reg))
        else $error("column write beyond query length");

    // a result never overwrites one still waiting
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result loaded while output busy");

endmodule

[src/pedf_ctrl.sv]
// Controller fsm: decodes requests and sequences row sweeps and result emission
// Depends on pedf_pkg
`timescale 1ns / 1ps

module pedf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           op,
    input  pedf_pkg::dp_status_t status,
    output pedf_pkg::ctrl_cmd_t  cmd
);

    import pedf_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        pad_reg;
    logic        pad_next;
    logic        in_fire;
    op_t         op_dec;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign op_dec   = op_t'(op);

    // state and pad flag registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pad_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pad_reg   <= pad_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        pad_next   = pad_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (op_dec)
                        OP_CAND:
                        begin
                            if (!status.dropped && status.rows_short)
                            begin
                                state_next = ST_ROW;
                                pad_next   = 1'b0;
                            end
                        end
                        OP_END:
                        begin
                            if (!status.ql_zero && status.rows_short)
                            begin
                                state_next = ST_ROW;
                                pad_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_FINISH;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ROW:
            begin
                if (status.row_last)
                begin
                    if (!pad_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (!status.rows_short)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (op_dec)
                        OP_CLEAR:
                        begin
                            cmd.clear_query = 1'b1;
                            cmd.restart     = 1'b1;
                        end
                        OP_APPEND:
                        begin
                            cmd.append  = 1'b1;
                            cmd.restart = 1'b1;
                        end
                        OP_CAND:
                        begin
                            cmd.start_row = !status.dropped && status.rows_short;
                        end
                        OP_END:
                        begin
                            cmd.start_row = !status.ql_zero && status.rows_short;
                            cmd.pad       = 1'b1;
                        end
                        default:
                        begin
                            cmd = '0;
                        end
                    endcase
                end
            end
            ST_ROW:
            begin
                cmd.run = 1'b1;
                if (status.row_last && pad_reg && status.rows_short)
                begin
                    cmd.start_row = 1'b1;
                    cmd.pad       = 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.restart = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // a candidate row sweep hands control back at its last cell
    a_row_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROW && status.row_last && !pad_reg) |=> (state_reg == ST_IDLE))
        else $error("candidate row did not return to idle");

    // a row is only started while rows remain
    a_start_short: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_row |-> status.rows_short)
        else $error("row started with no rows left");

endmodule

[bench/prefix_edit_distance_filter_unit_tb.sv]
// Self-checking bench for prefix_edit_distance_filter_unit: query loads, candidate streams
// and register writes, with the distance and match flag predicted in a scoreboard class.
// Depends on pedf_pkg and the prefix_edit_distance_filter_unit RTL.
`timescale 1ns / 1ps

module prefix_edit_distance_filter_unit_tb;

    import pedf_pkg::*;

    localparam int MAX_Q      = MAX_QUERY_LEN_DEF;
    localparam int DW         = $clog2(MAX_Q + 1);
    localparam int CW         = $clog2(MAX_Q + 2);
    // a candidate char sweeps the whole column, so allow that much after the last result
    localparam int SETTLE     = MAX_Q + 16;
    // longest silent stretch: full padding of a 64-char query plus output stall
    localparam int QUIET_MAX  = 20000;
    localparam int PHASE_REQS = 670;

    typedef struct {
        logic [DW-1:0] distance;
        logic          is_match;
    } distance_result_t;

    // scoreboard: keeps its own query, dp column and registers
    class prefix_distance_predictor;
        bit [7:0]         query_q[MAX_Q];
        int unsigned      query_len;
        int unsigned      column[MAX_Q + 1];
        int unsigned      rows_seen;
        bit [CW-1:0]      threshold;
        bit               skip_space;
        distance_result_t pending_distances[$];
        int unsigned      errors;
        int unsigned      results_checked;
        int unsigned      match_count;

        function new();
            threshold       = CW'(THRESHOLD_RESET);
            skip_space      = SKIP_RESET;
            query_len       = 0;
            errors          = 0;
            results_checked = 0;
            match_count     = 0;
            restart();
        endfunction

        function void restart();
            for (int y = 0; y <= MAX_Q; y++)
                column[y] = y;
            rows_seen = 0;
        endfunction

        function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [CW-1:0] data);
            if (idx == CFG_THRESHOLD)
                threshold = data;
            else if (idx == CFG_SKIP)
                skip_space = data[0];
        endfunction

        // one candidate row of the column; pad mismatches every query char
        function void advance_row(bit [7:0] c, bit pad);
            int unsigned diag;
            int unsigned above;
            int unsigned best;
            diag = column[0];
            rows_seen++;
            column[0] = rows_seen;
            for (int y = 1; y <= query_len; y++) begin
                above = column[y];
                best  = above + 1;
                if (column[y-1] + 1 < best)
                    best = column[y-1] + 1;
                if (diag + ((pad || query_q[y-1] != c) ? 1 : 0) < best)
                    best = diag + ((pad || query_q[y-1] != c) ? 1 : 0);
                column[y] = best;
                diag = above;
            end
        endfunction

        function void take_request(op_t code, bit [7:0] c);
            bit               dropped;
            int unsigned      total;
            distance_result_t res;
            dropped = skip_space && (c == SPACE_CHAR);
            case (code)
                OP_CLEAR:
                begin
                    query_len = 0;
                    restart();
                end
                OP_APPEND:
                begin
                    restart();
                    if (!dropped && query_len < MAX_Q)
                    begin
                        query_q[query_len] = c;
                        query_len++;
                    end
                end
                OP_CAND:
                begin
                    if (!dropped && rows_seen < query_len)
                        advance_row(c, 1'b0);
                end
                default:
                begin
                    total = 0;
                    if (query_len != 0)
                    begin
                        while (rows_seen < query_len)
                            advance_row(8'h00, 1'b1);
                        total = column[query_len];
                    end
                    res.distance = total[DW-1:0];
                    res.is_match = (total < threshold);
                    pending_distances.push_back(res);
                    restart();
                end
            endcase
        endfunction

        function void check_distance(logic [DW-1:0] d, logic m);
            distance_result_t want;
            if (pending_distances.size() == 0)
            begin
                $display("%0t: unexpected result: distance %0d is_match %0b", $time, d, m);
                errors++;
                return;
            end
            want = pending_distances.pop_front();
            results_checked++;
            if (m === 1'b1)
                match_count++;
            if (d !== want.distance)
            begin
                $display("%0t: distance mismatch: expected %0d, actual %0d",
                         $time, want.distance, d);
                errors++;
            end
            if (m !== want.is_match)
            begin
                $display("%0t: is_match mismatch: expected %0b, actual %0b",
                         $time, want.is_match, m);
                errors++;
            end
        endfunction

        function int pending();
            return pending_distances.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           op;
    logic [7:0]           ch;
    logic                 out_valid;
    logic                 out_ready;
    logic [DW-1:0]        distance;
    logic                 is_match;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CW-1:0]        cfg_data;

    prefix_distance_predictor sb;
    int unsigned              quiet_cycles;
    int unsigned              reqs_sent;
    int unsigned              cfg_settings;
    int                       tx_idle_pct;
    int                       rx_idle_pct;

    prefix_edit_distance_filter_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .ch        (ch),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .distance  (distance),
        .is_match  (is_match),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver back-pressure, changed on the falling edge
    always @(negedge clk)
    begin
        out_ready = ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // monitor: note accepted requests, check accepted results, count silent cycles
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.take_request(op_t'(op), ch);
            if (out_valid && out_ready)
                sb.check_distance(distance, is_match);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // watchdog
    initial
    begin
        wait (rst_n === 1'b1);
        while (quiet_cycles < QUIET_MAX)
            @(posedge clk);
        $display("timeout: no handshake for %0d cycles", QUIET_MAX);
        $display("DONE: errors detected");
        $finish;
    end

    // one request; called right after a falling edge
    task automatic send_req(op_t code, bit [7:0] c);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        op       = code;
        ch       = c;
        do
            @(posedge clk);
        while (!in_ready);
        reqs_sent++;
        @(negedge clk);
    endtask

    // hold off until every expected result is back, then let the bench settle
    task automatic drain(int extra);
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(bit [CFG_IDX_W-1:0] idx, bit [CW-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_regs(bit [CW-1:0] thr, bit skip);
        drain(SETTLE);
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_SKIP, {{(CW-1){1'b0}}, skip});
        cfg_settings++;
    endtask

    // small alphabet for near matches, plus spaces, zero bytes and any byte
    function automatic bit [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 8'h61 + 8'($urandom_range(0, 3));
        else if (r < 72)
            return SPACE_CHAR;
        else if (r < 78)
            return 8'h00;
        else if (r < 84)
            return 8'hff;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // clear, load a query, then stream edited copies of it as candidates
    task automatic query_session(bit long_query);
        bit [7:0] qs[$];
        bit [7:0] cand[$];
        int       n;
        int       pos;
        int       kind;
        int       r;
        send_req(OP_CLEAR, 8'($urandom_range(0, 255)));
        n = long_query ? $urandom_range(60, 72) : $urandom_range(0, 12);
        repeat (n) qs.push_back(pick_char());
        foreach (qs[i])
            send_req(OP_APPEND, qs[i]);
        repeat (long_query ? $urandom_range(1, 2) : $urandom_range(1, 5))
        begin
            cand = qs;
            // a few substitutions, insertions and deletions
            repeat ($urandom_range(0, 3))
            begin
                pos  = $urandom_range(0, cand.size());
                kind = $urandom_range(0, 2);
                if (cand.size() == 0 || kind == 0)
                    cand.insert(pos, pick_char());
                else if (kind == 1)
                    cand[pos % cand.size()] = pick_char();
                else
                    cand.delete(pos % cand.size());
            end
            // sometimes longer than the query, sometimes cut short
            r = $urandom_range(0, 9);
            if (r < 2)
                repeat ($urandom_range(1, 6)) cand.push_back(pick_char());
            else if (r < 4 && cand.size() > 0)
            begin
                n = $urandom_range(0, cand.size() - 1);
                while (cand.size() > n)
                    void'(cand.pop_back());
            end
            foreach (cand[i])
            begin
                // query edit in the middle of a candidate
                if ($urandom_range(0, 99) < 2)
                    send_req(OP_APPEND, pick_char());
                send_req(OP_CAND, cand[i]);
            end
            send_req(OP_END, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(1, 6))
            send_req(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    endtask

    int          tx_pct_tbl[3]  = '{25, 70, 0};
    int          rx_pct_tbl[3]  = '{70, 25, 0};
    bit [CW-1:0] thr_tbl[3];
    bit          skip_tbl[3]    = '{1'b1, 1'b0, 1'b1};

    initial
    begin
        int unsigned phase_end;
        int          r;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        op           = OP_CLEAR;
        ch           = 8'h00;
        out_ready    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_THRESHOLD;
        cfg_data     = '0;
        quiet_cycles = 0;
        reqs_sent    = 0;
        cfg_settings = 1;
        tx_idle_pct  = tx_pct_tbl[0];
        rx_idle_pct  = rx_pct_tbl[0];
        thr_tbl      = '{7'd63, 7'd65, CW'($urandom_range(1, 8))};
        sb           = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset settings
        send_req(OP_END, 8'h5a);            // empty query
        send_req(OP_CLEAR, 8'hff);
        send_req(OP_APPEND, 8'h61);
        send_req(OP_APPEND, SPACE_CHAR);    // dropped
        send_req(OP_APPEND, 8'h00);         // zero byte is a normal char
        send_req(OP_APPEND, 8'hff);
        send_req(OP_CAND, 8'h61);
        send_req(OP_CAND, SPACE_CHAR);      // dropped
        send_req(OP_CAND, 8'h00);
        send_req(OP_CAND, 8'h78);
        send_req(OP_CAND, 8'h79);           // past the query length
        send_req(OP_END, 8'h00);
        send_req(OP_CAND, 8'hff);
        send_req(OP_END, 8'hff);            // short candidate gets padded
        send_req(OP_CAND, 8'h61);
        send_req(OP_APPEND, 8'h62);         // abandons the candidate
        send_req(OP_END, 8'h00);

        // directed: spaces kept, threshold zero
        set_regs(7'd0, 1'b0);
        send_req(OP_CLEAR, 8'h00);
        send_req(OP_APPEND, SPACE_CHAR);
        send_req(OP_APPEND, 8'h71);
        send_req(OP_CAND, SPACE_CHAR);
        send_req(OP_CAND, 8'h71);
        send_req(OP_END, 8'h00);

        // random phases, each opening with a long query that may overflow capacity
        for (int p = 0; p < 3; p++)
        begin
            set_regs(thr_tbl[p], skip_tbl[p]);
            tx_idle_pct = tx_pct_tbl[p];
            rx_idle_pct = rx_pct_tbl[p];
            phase_end   = reqs_sent + PHASE_REQS;
            query_session(1'b1);
            while (reqs_sent < phase_end)
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                    query_session(1'b1);
                else if (r < 83)
                    query_session(1'b0);
                else if (r < 95)
                    noise_burst();
                else
                    drain(0);
            end
        end

        drain(SETTLE);
        $display("Sent %0d requests under %0d register settings and three idle patterns;",
                 reqs_sent, cfg_settings);
        $display("checked %0d results, %0d of them matches.", sb.results_checked, sb.match_count);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[sim.f]
src/pedf_pkg.sv
src/pedf_ram.sv
src/pedf_datapath.sv
src/pedf_ctrl.sv
src/prefix_edit_distance_filter_unit.sv
bench/prefix_edit_distance_filter_unit_tb.sv
